// ===== src/erb_pkg.sv =====
// Shared types and constants of the rotation and strain builder.
package erb_pkg;

  // Fixed-point constants, Q30 unless stated otherwise; RotOne is Q16.
  localparam int unsigned TableLen = 24;
  localparam logic signed [35:0] Q30Pi = 36'sd3373259426;
  localparam logic signed [35:0] Q30HalfPi = 36'sd1686629713;
  localparam logic signed [35:0] CordicGain = 36'sd652032874;
  localparam logic signed [17:0] RotOne = 18'sd65536;
  localparam logic [3:0] DofRot = 4'd3;
  localparam logic [3:0] DofStrain = 4'd6;

  // One item as it travels from the front end to the back end.
  typedef struct packed {
    logic        upd_rot;
    logic        upd_strain;
    logic [17:0] phi;
    logic [17:0] theta;
    logic [17:0] psi;
    logic [31:0] s_xx;
    logic [31:0] s_yy;
    logic [31:0] s_zz;
    logic [31:0] s_xy;
    logic [31:0] s_yz;
    logic [31:0] s_xz;
  } erb_item_t;

  // Arctangent table, floor(atan(2^-i) * 2^30).
  function automatic logic signed [35:0] erb_atan(input logic [4:0] idx);
    logic signed [35:0] v;
    case (idx)
      5'd0: v = 36'sd843314856;
      5'd1: v = 36'sd497837829;
      5'd2: v = 36'sd263043836;
      5'd3: v = 36'sd133525158;
      5'd4: v = 36'sd67021686;
      5'd5: v = 36'sd33543515;
      5'd6: v = 36'sd16775850;
      5'd7: v = 36'sd8388437;
      5'd8: v = 36'sd4194282;
      5'd9: v = 36'sd2097149;
      5'd10: v = 36'sd1048575;
      5'd11: v = 36'sd524287;
      5'd12: v = 36'sd262143;
      5'd13: v = 36'sd131071;
      5'd14: v = 36'sd65535;
      5'd15: v = 36'sd32767;
      5'd16: v = 36'sd16383;
      5'd17: v = 36'sd8191;
      5'd18: v = 36'sd4095;
      5'd19: v = 36'sd2047;
      5'd20: v = 36'sd1023;
      5'd21: v = 36'sd511;
      5'd22: v = 36'sd255;
      5'd23: v = 36'sd127;
      default: v = 36'sd0;
    endcase
    return v;
  endfunction

endpackage

// ===== src/erb_front.sv =====
// Front end: classifies items and holds them in a two-entry queue.
module erb_front
  import erb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [3:0]  dof_count,
  input  logic [17:0] angle_phi,
  input  logic [17:0] angle_theta,
  input  logic [17:0] angle_psi,
  input  logic [31:0] strain_xx,
  input  logic [31:0] strain_yy,
  input  logic [31:0] strain_zz,
  input  logic [31:0] strain_xy,
  input  logic [31:0] strain_yz,
  input  logic [31:0] strain_xz,
  output logic        q_valid,
  input  logic        q_take,
  output erb_item_t   q_item
);

  erb_item_t  mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr, rd;
  erb_item_t  item;

  assign full = (cnt_r == 2'd2);
  assign wr = push && !full;
  assign rd = q_take && q_valid;
  assign q_valid = (cnt_r != 2'd0);
  assign q_item = mem_r[rp_r];

  // Classify by the count of active degrees of freedom.
  always_comb begin
    item.upd_rot = (dof_count > DofRot);
    item.upd_strain = (dof_count > DofStrain);
    item.phi = angle_phi;
    item.theta = angle_theta;
    item.psi = angle_psi;
    item.s_xx = strain_xx;
    item.s_yy = strain_yy;
    item.s_zz = strain_zz;
    item.s_xy = strain_xy;
    item.s_yz = strain_yz;
    item.s_xz = strain_xz;
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wp_r] <= item;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr) begin
        wp_r <= ~wp_r;
      end
      if (rd) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

// ===== src/erb_back.sv =====
// Back end: CORDIC sine and cosine, matrix products, stores and result rows.
module erb_back
  import erb_pkg::*;
#(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  output logic        q_take,
  input  erb_item_t   q_item,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  row_index,
  output logic [17:0] rot_col0,
  output logic [17:0] rot_col1,
  output logic [17:0] rot_col2,
  output logic [31:0] strain_col0,
  output logic [31:0] strain_col1,
  output logic [31:0] strain_col2,
  output logic        last_row
);

  localparam int unsigned Steps = (CORDIC_STEPS < TableLen) ? CORDIC_STEPS : TableLen;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StLoad = 3'd1;
  localparam logic [2:0] StCord = 3'd2;
  localparam logic [2:0] StMul = 3'd3;
  localparam logic [2:0] StOut = 3'd4;

  logic [2:0] st_r;
  erb_item_t  it_r;
  logic [1:0] ang_r;
  logic [4:0] step_r;
  logic [4:0] mstep_r;
  logic [1:0] row_r;

  // CORDIC registers, Q30 in 36 bits.
  logic signed [35:0] x_r, y_r, z_r;
  logic               flip_r;
  logic signed [35:0] sin_r [3];
  logic signed [35:0] cos_r [3];

  // Product registers.
  logic signed [35:0] pa_r, pb_r;
  logic signed [35:0] prod_r;
  logic signed [35:0] t_r [6];
  logic signed [35:0] pa_nxt, pb_nxt;

  logic signed [17:0] rot_r [9];
  logic [31:0]        str_r [6];

  logic signed [35:0] z0, zr, xs, ys, at;
  logic               fl;
  logic [17:0]        ang;
  logic signed [71:0] mp;
  logic signed [35:0] mr;

  // Angle selection and range reduction.
  always_comb begin
    case (ang_r)
      2'd0: ang = it_r.phi;
      2'd1: ang = it_r.theta;
      default: ang = it_r.psi;
    endcase
    z0 = {{3{ang[17]}}, ang, 15'd0};
    fl = 1'b0;
    zr = z0;
    if (z0 > Q30HalfPi) begin
      zr = z0 - Q30Pi;
      fl = 1'b1;
    end else if (z0 < -Q30HalfPi) begin
      zr = z0 + Q30Pi;
      fl = 1'b1;
    end
    xs = x_r >>> step_r;
    ys = y_r >>> step_r;
    at = erb_atan(step_r);
  end

  // Rounded Q30 product of the operand registers.
  assign mp = pa_r * pb_r + 72'sd536870912;
  assign mr = 36'(mp >>> 30);

  function automatic logic signed [17:0] to_q16(input logic signed [35:0] v);
    logic signed [35:0] r;
    r = (v + 36'sd8192) >>> 14;
    if (r > 36'sd65536) begin
      r = 36'sd65536;
    end
    if (r < -36'sd65536) begin
      r = -36'sd65536;
    end
    return r[17:0];
  endfunction

  // Operand schedule for the product sequence: 14 multiplies.
  // Indices into sin/cos: 0 phi, 1 theta, 2 psi.
  always_comb begin
    pa_nxt = '0;
    pb_nxt = '0;
    case (mstep_r)
      5'd0: begin pa_nxt = sin_r[2]; pb_nxt = sin_r[1]; end
      5'd1: begin pa_nxt = cos_r[2]; pb_nxt = sin_r[1]; end
      5'd2: begin pa_nxt = cos_r[1]; pb_nxt = cos_r[0]; end
      5'd3: begin pa_nxt = cos_r[1]; pb_nxt = sin_r[0]; end
      5'd4: begin pa_nxt = t_r[0]; pb_nxt = cos_r[0]; end
      5'd5: begin pa_nxt = cos_r[2]; pb_nxt = sin_r[0]; end
      5'd6: begin pa_nxt = t_r[0]; pb_nxt = sin_r[0]; end
      5'd7: begin pa_nxt = cos_r[2]; pb_nxt = cos_r[0]; end
      5'd8: begin pa_nxt = cos_r[1]; pb_nxt = sin_r[2]; end
      5'd9: begin pa_nxt = t_r[1]; pb_nxt = cos_r[0]; end
      5'd10: begin pa_nxt = sin_r[2]; pb_nxt = sin_r[0]; end
      5'd11: begin pa_nxt = t_r[1]; pb_nxt = sin_r[0]; end
      5'd12: begin pa_nxt = sin_r[2]; pb_nxt = cos_r[0]; end
      5'd13: begin pa_nxt = cos_r[1]; pb_nxt = cos_r[2]; end
      default: begin pa_nxt = '0; pb_nxt = '0; end
    endcase
  end

  assign q_take = (st_r == StIdle) && q_valid;
  assign empty = (st_r != StOut);
  assign row_index = row_r;
  assign last_row = (row_r == 2'd2);

  // Row output selection.
  always_comb begin
    case (row_r)
      2'd0: begin
        rot_col0 = rot_r[0]; rot_col1 = rot_r[1]; rot_col2 = rot_r[2];
        strain_col0 = str_r[0]; strain_col1 = str_r[3]; strain_col2 = str_r[5];
      end
      2'd1: begin
        rot_col0 = rot_r[3]; rot_col1 = rot_r[4]; rot_col2 = rot_r[5];
        strain_col0 = str_r[3]; strain_col1 = str_r[1]; strain_col2 = str_r[4];
      end
      default: begin
        rot_col0 = rot_r[6]; rot_col1 = rot_r[7]; rot_col2 = rot_r[8];
        strain_col0 = str_r[5]; strain_col1 = str_r[4]; strain_col2 = str_r[2];
      end
    endcase
  end

  // Sequencer: load angles, CORDIC, multiply if rotating; emit three rows.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= StIdle;
      row_r <= 2'd0;
      ang_r <= 2'd0;
      step_r <= 5'd0;
      mstep_r <= 5'd0;
      for (int k = 0; k < 9; k++) begin
        rot_r[k] <= (k % 4 == 0) ? RotOne : 18'sd0;
      end
      for (int k = 0; k < 6; k++) begin
        str_r[k] <= 32'd0;
      end
    end else begin
      case (st_r)
        StIdle: begin
          if (q_valid) begin
            it_r <= q_item;
            ang_r <= 2'd0;
            if (q_item.upd_strain) begin
              str_r[0] <= q_item.s_xx;
              str_r[1] <= q_item.s_yy;
              str_r[2] <= q_item.s_zz;
              str_r[3] <= q_item.s_xy;
              str_r[4] <= q_item.s_yz;
              str_r[5] <= q_item.s_xz;
            end
            st_r <= q_item.upd_rot ? StLoad : StOut;
            row_r <= 2'd0;
          end
        end
        StLoad: begin
          x_r <= CordicGain;
          y_r <= 36'sd0;
          z_r <= zr;
          flip_r <= fl;
          step_r <= 5'd0;
          st_r <= StCord;
        end
        StCord: begin
          if (!z_r[35]) begin
            x_r <= x_r - ys;
            y_r <= y_r + xs;
            z_r <= z_r - at;
          end else begin
            x_r <= x_r + ys;
            y_r <= y_r - xs;
            z_r <= z_r + at;
          end
          if (step_r == 5'(Steps - 1)) begin
            st_r <= StLoad;
            ang_r <= ang_r + 2'd1;
            if (ang_r == 2'd2) begin
              st_r <= StMul;
              mstep_r <= 5'd0;
            end
          end else begin
            step_r <= step_r + 5'd1;
          end
        end
        StMul: begin
          // Operands registered one step, product the next.
          pa_r <= pa_nxt;
          pb_r <= pb_nxt;
          prod_r <= mr;
          mstep_r <= mstep_r + 5'd1;
          case (mstep_r)
            5'd2: t_r[0] <= prod_r;
            5'd3: t_r[1] <= prod_r;
            5'd4: rot_r[0] <= to_q16(prod_r);
            5'd5: begin
              rot_r[1] <= to_q16(prod_r);
              rot_r[2] <= to_q16(-sin_r[1]);
            end
            5'd6: t_r[2] <= prod_r;
            5'd7: rot_r[3] <= to_q16(t_r[2] - prod_r);
            5'd8: t_r[3] <= prod_r;
            5'd9: rot_r[4] <= to_q16(t_r[3] + prod_r);
            5'd10: rot_r[5] <= to_q16(prod_r);
            5'd11: t_r[4] <= prod_r;
            5'd12: rot_r[6] <= to_q16(t_r[4] + prod_r);
            5'd13: t_r[5] <= prod_r;
            5'd14: rot_r[7] <= to_q16(t_r[5] - prod_r);
            5'd15: begin
              rot_r[8] <= to_q16(prod_r);
              st_r <= StOut;
              row_r <= 2'd0;
            end
            default: ;
          endcase
        end
        StOut: begin
          if (pop) begin
            row_r <= row_r + 2'd1;
            if (row_r == 2'd2) begin
              st_r <= StIdle;
            end
          end
        end
        default: st_r <= StIdle;
      endcase
    end
  end

  // Capture sine and cosine at the end of each CORDIC run.
  always_ff @(posedge clk) begin
    if (st_r == StCord && step_r == 5'(Steps - 1)) begin
      if (!z_r[35]) begin
        sin_r[ang_r] <= flip_r ? -(y_r + xs) : (y_r + xs);
        cos_r[ang_r] <= flip_r ? -(x_r - ys) : (x_r - ys);
      end else begin
        sin_r[ang_r] <= flip_r ? -(y_r - xs) : (y_r - xs);
        cos_r[ang_r] <= flip_r ? -(x_r + ys) : (x_r + ys);
      end
    end
  end

endmodule

// ===== src/euler_rotation_and_strain_builder_unit.sv =====
// Top level of the roll-pitch-yaw rotation and strain builder.
// An item that rebuilds the rotation runs its three angles through the shared CORDIC
// unit and its products through one multiplier before the first row; other items go
// straight to the rows. Three row transfers follow.
// A two-entry queue lets the front end accept items while the back end works.
// Synchronous active-low reset: identity matrix, zero strain, queue and back end empty.
module euler_rotation_and_strain_builder_unit
  import erb_pkg::*;
#(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [3:0]  in_dof_count,
  input  logic [17:0] in_angle_phi,
  input  logic [17:0] in_angle_theta,
  input  logic [17:0] in_angle_psi,
  input  logic [31:0] in_strain_xx,
  input  logic [31:0] in_strain_yy,
  input  logic [31:0] in_strain_zz,
  input  logic [31:0] in_strain_xy,
  input  logic [31:0] in_strain_yz,
  input  logic [31:0] in_strain_xz,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  out_row_index,
  output logic [17:0] out_rot_col0,
  output logic [17:0] out_rot_col1,
  output logic [17:0] out_rot_col2,
  output logic [31:0] out_strain_col0,
  output logic [31:0] out_strain_col1,
  output logic [31:0] out_strain_col2,
  output logic        out_last_row
);

  logic      q_valid, q_take;
  erb_item_t q_item;

  erb_front u_front (
    .clk, .rst_n, .push, .full,
    .dof_count(in_dof_count), .angle_phi(in_angle_phi),
    .angle_theta(in_angle_theta), .angle_psi(in_angle_psi),
    .strain_xx(in_strain_xx), .strain_yy(in_strain_yy), .strain_zz(in_strain_zz),
    .strain_xy(in_strain_xy), .strain_yz(in_strain_yz), .strain_xz(in_strain_xz),
    .q_valid, .q_take, .q_item
  );

  erb_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk, .rst_n, .q_valid, .q_take, .q_item, .empty, .pop,
    .row_index(out_row_index), .rot_col0(out_rot_col0), .rot_col1(out_rot_col1),
    .rot_col2(out_rot_col2), .strain_col0(out_strain_col0),
    .strain_col1(out_strain_col1), .strain_col2(out_strain_col2),
    .last_row(out_last_row)
  );

  // The last row is flagged exactly on row two.
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_last_row == (out_row_index == 2'd2)))
    else $error("last_row does not match row index");

  // No result is shown right after reset.
  a_rst: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result shown right after reset");

  // A row that is not taken stays in place.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_row_index)))
    else $error("result row changed without a transfer");

endmodule
